### rtl/sfp_pkg.sv
// package: shared types, sizes and codes for the snapshot frame parser
`timescale 1ns / 1ps

package sfp_pkg;

  // frame geometry
  localparam int HEADER_BYTES = 8;
  localparam int RECORD_BYTES = 16;
  localparam int POS_W        = 6;
  localparam int HIDX_W       = $clog2(HEADER_BYTES);
  localparam int RIDX_W       = $clog2(RECORD_BYTES);

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // register file
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPORTED_MAJOR    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROVIDER_COUNT = 1'b1;
  localparam logic [7:0] SUPPORTED_MAJOR_RESET    = 8'd1;
  localparam logic [7:0] MAX_PROVIDER_COUNT_RESET = 8'd4;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [7:0] ST_OK       = 8'd0;
  localparam logic [7:0] ST_SHORT    = 8'd1;
  localparam logic [7:0] ST_NEWMAJOR = 8'd2;
  localparam logic [7:0] ST_BADCOUNT = 8'd3;

  // sentinels
  localparam logic [7:0]  PCT_ABSENT     = 8'hFF;
  localparam logic [15:0] CREDITS_ABSENT = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_RECORDS = 3'b010,
    PH_DROP    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  index_count_or_code;
    logic [7:0]  id_or_major;
    logic [7:0]  status_or_minor;
    logic [7:0]  plan_or_flags;
    logic [7:0]  session_pct;
    logic [7:0]  week_pct;
    logic [31:0] reset_or_captured;
    logic [31:0] week_reset_time;
    logic [15:0] credits_times_ten;
    logic [4:0]  present_mask;
    logic        last_of_run;
  } result_t;

  // up to two results produced by one byte, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

### rtl/snapshot_frame_parser_top.sv
// top level: snapshot frame parser with byte input and result output channels
//
// Input channel (in_valid/in_ready/in_data) carries one frame byte per transfer
// with an end-of-buffer flag. Output channel (out_valid/out_ready/out_data)
// carries header, record and status results, one per transfer; last_of_run
// marks the final result caused by one byte. The register port (cfg_we,
// cfg_index, cfg_data) writes the supported major version or the largest
// record count, one register per write; write it only while the block is idle.
// Throughput: one byte per cycle while in_ready is high. A byte yields zero,
// one or two results; the first reaches the output in the cycle after the
// byte's transfer when the queue is empty; a second once the first is taken.
// The parser updates its phase, counters and one stored byte per byte and
// forms a result from the stores plus the incoming byte in the same cycle.
// Results wait in a four-entry queue; in_ready drops only when fewer than two
// entries are free, so a stalled receiver backs up into the input after a few
// results. Reset (synchronous, active high) empties the queue, returns the
// parser to the header phase and restores the register defaults.
`timescale 1ns / 1ps

module snapshot_frame_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sfp_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sfp_pkg::result_t                out_data,
  input  logic                            cfg_we,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sfp_pkg::*;

  push_t push;
  logic  take;

  assign take = in_valid && in_ready;

  // byte parser
  sfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .item      (in_data),
    .push      (push)
  );

  // result queue
  sfp_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/sfp_parser.sv
// frame parser: phase tracking, byte stores and result formation per byte
`timescale 1ns / 1ps

module sfp_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            take,
  input  sfp_pkg::in_item_t               item,
  output sfp_pkg::push_t                  push
);
  import sfp_pkg::*;

  // control state
  phase_t             phase, phase_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [7:0]         record_number, record_number_next;
  logic [7:0]         announced_count, announced_count_next;
  logic [7:0]         supported_major, max_provider_count;

  // byte stores
  logic [7:0] header_store [HEADER_BYTES];
  logic [7:0] record_store [RECORD_BYTES];

  // views with the current byte in the final slot
  logic [7:0] hv [HEADER_BYTES];
  logic [7:0] rv [RECORD_BYTES];

  logic [POS_W-1:0] pos_inc;
  logic             data_emit, status_emit, errored;
  logic [7:0]       status_code;
  result_t          data_res, status_res;
  logic [31:0]      sr, wr;
  logic [15:0]      cr;

  assign pos_inc = byte_position + POS_W'(1);

  // byte views
  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hv[i] = (i == HEADER_BYTES - 1) ? item.data_byte : header_store[i];
    end
    for (int i = 0; i < RECORD_BYTES; i++) begin
      rv[i] = (i == RECORD_BYTES - 1) ? item.data_byte : record_store[i];
    end
  end

  assign sr = {rv[7], rv[6], rv[5], rv[4]};
  assign wr = {rv[11], rv[10], rv[9], rv[8]};
  assign cr = {rv[13], rv[12]};

  // per-byte decisions
  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    record_number_next   = record_number;
    announced_count_next = announced_count;
    data_emit            = 1'b0;
    status_emit          = 1'b0;
    errored              = 1'b0;
    status_code          = ST_OK;
    data_res             = '0;

    case (phase)
      PH_HEADER: begin
        byte_position_next = pos_inc;
        if (pos_inc >= POS_W'(HEADER_BYTES)) begin
          data_emit                     = 1'b1;
          data_res.result_kind          = KIND_HEADER;
          data_res.index_count_or_code  = hv[2];
          data_res.id_or_major          = hv[0];
          data_res.status_or_minor      = hv[1];
          data_res.plan_or_flags        = hv[3];
          data_res.reset_or_captured    = {hv[7], hv[6], hv[5], hv[4]};
          byte_position_next            = '0;
          record_number_next            = '0;
          announced_count_next          = hv[2];
          if (hv[0] > supported_major) begin
            errored     = 1'b1;
            status_code = ST_NEWMAJOR;
          end else if (hv[2] > max_provider_count) begin
            errored     = 1'b1;
            status_code = ST_BADCOUNT;
          end
          phase_next  = errored ? PH_DROP : PH_RECORDS;
          status_emit = errored;
        end
      end
      PH_RECORDS: begin
        if (record_number < announced_count) begin
          byte_position_next = pos_inc;
          if (pos_inc >= POS_W'(RECORD_BYTES)) begin
            data_emit                    = 1'b1;
            data_res.result_kind         = KIND_RECORD;
            data_res.index_count_or_code = record_number;
            data_res.id_or_major         = rv[0];
            data_res.status_or_minor     = rv[1];
            data_res.plan_or_flags       = rv[14];
            if (rv[2] != PCT_ABSENT) begin
              data_res.session_pct     = rv[2];
              data_res.present_mask[0] = 1'b1;
            end
            if (rv[3] != PCT_ABSENT) begin
              data_res.week_pct        = rv[3];
              data_res.present_mask[1] = 1'b1;
            end
            if (sr != '0) begin
              data_res.reset_or_captured = sr;
              data_res.present_mask[2]   = 1'b1;
            end
            if (wr != '0) begin
              data_res.week_reset_time = wr;
              data_res.present_mask[3] = 1'b1;
            end
            if (cr != CREDITS_ABSENT) begin
              data_res.credits_times_ten = cr;
              data_res.present_mask[4]   = 1'b1;
            end
            record_number_next = record_number + 8'd1;
            byte_position_next = '0;
          end
        end
      end
      default: begin
        // drop phase: bytes are ignored
      end
    endcase

    // end of buffer closes the frame
    if (item.end_of_buffer) begin
      if (!errored) begin
        if (phase_next == PH_HEADER) begin
          status_emit = 1'b1;
          status_code = ST_SHORT;
        end else if (phase_next == PH_RECORDS) begin
          status_emit = 1'b1;
          status_code = (record_number_next >= announced_count_next) ? ST_OK : ST_SHORT;
        end
      end
      phase_next           = PH_HEADER;
      byte_position_next   = '0;
      record_number_next   = '0;
      announced_count_next = '0;
    end
  end

  // status result and ordering of the pushed pair
  always_comb begin
    status_res                     = '0;
    status_res.result_kind         = KIND_STATUS;
    status_res.index_count_or_code = status_code;
    status_res.last_of_run         = 1'b1;

    push = '0;
    if (take) begin
      push.count = {1'b0, data_emit} + {1'b0, status_emit};
      if (data_emit) begin
        push.first             = data_res;
        push.first.last_of_run = !status_emit;
        push.second            = status_res;
      end else begin
        push.first = status_res;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HEADER;
      byte_position      <= '0;
      record_number      <= '0;
      announced_count    <= '0;
      supported_major    <= SUPPORTED_MAJOR_RESET;
      max_provider_count <= MAX_PROVIDER_COUNT_RESET;
    end else begin
      if (take) begin
        phase           <= phase_next;
        byte_position   <= byte_position_next;
        record_number   <= record_number_next;
        announced_count <= announced_count_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SUPPORTED_MAJOR:    supported_major    <= cfg_data[7:0];
          CFG_MAX_PROVIDER_COUNT: max_provider_count <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (take) begin
      if (phase == PH_HEADER && byte_position < POS_W'(HEADER_BYTES)) begin
        header_store[byte_position[HIDX_W-1:0]] <= item.data_byte;
      end
      if (phase == PH_RECORDS && record_number < announced_count &&
          byte_position < POS_W'(RECORD_BYTES)) begin
        record_store[byte_position[RIDX_W-1:0]] <= item.data_byte;
      end
    end
  end

endmodule

### rtl/sfp_result_fifo.sv
// result queue: takes up to two results per cycle, hands out one per transfer
`timescale 1ns / 1ps

module sfp_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  sfp_pkg::push_t    push,
  output logic              space_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output sfp_pkg::result_t  out_data
);
  import sfp_pkg::*;

  result_t             entries [FIFO_DEPTH];
  logic [FPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [FCNT_W-1:0]   count, count_next;
  logic                pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  // room for a worst-case pair of results
  assign space_ok  = (count <= FCNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    count_next = count + FCNT_W'(push.count) - FCNT_W'(pop);
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + FPTR_W'(1);
      end
      count <= count_next;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + FPTR_W'(1)] <= push.second;
    end
  end

endmodule

### tb/sv/snapshot_frame_parser_top_test.sv
// testbench: snapshot frame parser driven with directed and random frames, checked by a predictor
`timescale 1ns / 1ps

module snapshot_frame_parser_top_test;
  import sfp_pkg::*;

  // one directed stimulus row; a typed row fixes the last result of its byte
  typedef struct {
    in_item_t item;
    bit       typed;
    result_t  want;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_item_t in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  result_t  out_data;
  logic     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SUPPORTED_MAJOR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // parser mirror: limits, phase, counters and byte stores
  logic [7:0] major_limit = SUPPORTED_MAJOR_RESET;
  logic [7:0] count_limit = MAX_PROVIDER_COUNT_RESET;
  phase_t     parse_phase = PH_HEADER;
  int         byte_pos = 0;
  logic [7:0] rec_num = '0;
  logic [7:0] announced = '0;
  logic [7:0] hdr_store [HEADER_BYTES];
  logic [7:0] rec_store [RECORD_BYTES];

  // results of the byte just parsed, and results still owed by the block
  result_t   byte_results [2];
  int        byte_result_n;
  result_t   owed_results [$];
  stim_row_t directed_rows [$];

  bit steady = 1'b0;
  int errors = 0;
  int frames = 0;
  int sent_bytes = 0;
  int kind_seen [3] = '{0, 0, 0};

  snapshot_frame_parser_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 19);
  endfunction

  function automatic void add_status(logic [7:0] code);
    result_t r;
    r = '0;
    r.result_kind = KIND_STATUS;
    r.index_count_or_code = code;
    byte_results[byte_result_n] = r;
    byte_result_n++;
  endfunction

  // advance the parser mirror by one byte and collect the results it causes
  function automatic void parse_byte(in_item_t it);
    result_t     r;
    logic [31:0] sess_reset, week_reset;
    logic [15:0] credits;
    bit          errored;
    byte_result_n = 0;
    errored = 1'b0;
    case (parse_phase)
      PH_HEADER: begin
        hdr_store[byte_pos] = it.data_byte;
        byte_pos++;
        if (byte_pos >= HEADER_BYTES) begin
          r = '0;
          r.result_kind = KIND_HEADER;
          r.index_count_or_code = hdr_store[2];
          r.id_or_major = hdr_store[0];
          r.status_or_minor = hdr_store[1];
          r.plan_or_flags = hdr_store[3];
          r.reset_or_captured = {hdr_store[7], hdr_store[6], hdr_store[5], hdr_store[4]};
          byte_results[0] = r;
          byte_result_n = 1;
          byte_pos = 0;
          rec_num = '0;
          announced = hdr_store[2];
          if (hdr_store[0] > major_limit) begin
            add_status(ST_NEWMAJOR);
            errored = 1'b1;
          end else if (hdr_store[2] > count_limit) begin
            add_status(ST_BADCOUNT);
            errored = 1'b1;
          end else begin
            parse_phase = PH_RECORDS;
          end
          if (errored) parse_phase = PH_DROP;
        end
      end
      PH_RECORDS: begin
        if (rec_num < announced) begin
          rec_store[byte_pos] = it.data_byte;
          byte_pos++;
          if (byte_pos >= RECORD_BYTES) begin
            sess_reset = {rec_store[7], rec_store[6], rec_store[5], rec_store[4]};
            week_reset = {rec_store[11], rec_store[10], rec_store[9], rec_store[8]};
            credits = {rec_store[13], rec_store[12]};
            r = '0;
            r.result_kind = KIND_RECORD;
            r.index_count_or_code = rec_num;
            r.id_or_major = rec_store[0];
            r.status_or_minor = rec_store[1];
            r.plan_or_flags = rec_store[14];
            // sentinel values read as absent fields
            if (rec_store[2] != PCT_ABSENT) begin
              r.session_pct = rec_store[2];
              r.present_mask[0] = 1'b1;
            end
            if (rec_store[3] != PCT_ABSENT) begin
              r.week_pct = rec_store[3];
              r.present_mask[1] = 1'b1;
            end
            if (sess_reset != 0) begin
              r.reset_or_captured = sess_reset;
              r.present_mask[2] = 1'b1;
            end
            if (week_reset != 0) begin
              r.week_reset_time = week_reset;
              r.present_mask[3] = 1'b1;
            end
            if (credits != CREDITS_ABSENT) begin
              r.credits_times_ten = credits;
              r.present_mask[4] = 1'b1;
            end
            byte_results[0] = r;
            byte_result_n = 1;
            rec_num++;
            byte_pos = 0;
          end
        end
      end
      default: ;
    endcase
    // end of buffer closes the frame
    if (it.end_of_buffer) begin
      if (!errored) begin
        if (parse_phase == PH_HEADER) add_status(ST_SHORT);
        else if (parse_phase == PH_RECORDS) add_status(rec_num >= announced ? ST_OK : ST_SHORT);
      end
      parse_phase = PH_HEADER;
      byte_pos = 0;
      rec_num = '0;
      announced = '0;
    end
    if (byte_result_n > 0) byte_results[byte_result_n-1].last_of_run = 1'b1;
  endfunction

  // offer one byte, then predict once the transfer happens
  task automatic send_byte(in_item_t it, bit typed = 1'b0, result_t want = '0);
    @(negedge clk);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
    parse_byte(it);
    if (typed) begin
      if (byte_result_n == 0) byte_result_n = 1;
      byte_results[byte_result_n-1] = want;
    end
    for (int i = 0; i < byte_result_n; i++) owed_results.push_back(byte_results[i]);
  endtask

  // drop valid and wait for every owed result plus the block's latency
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limits(logic [7:0] major, logic [7:0] count);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SUPPORTED_MAJOR;
    cfg_data <= major;
    major_limit = major;
    @(negedge clk);
    cfg_index <= CFG_MAX_PROVIDER_COUNT;
    cfg_data <= count;
    count_limit = count;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_row(logic [7:0] b, bit eob, bit typed = 1'b0,
                                  logic [7:0] code = ST_OK);
    stim_row_t row;
    row.item = {b, eob};
    row.typed = typed;
    row.want = '0;
    row.want.result_kind = KIND_STATUS;
    row.want.index_count_or_code = code;
    row.want.last_of_run = 1'b1;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [31:0] maybe_absent(logic [31:0] sentinel);
    return ($urandom_range(99) < 25) ? sentinel : $urandom;
  endfunction

  // one random frame: mostly well formed, some bad headers, truncations and noise
  task automatic play_random_frame();
    logic [7:0]  fb [$];
    logic [7:0]  major;
    logic [31:0] word;
    int          pick, count, cut;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 24)) fb.push_back(8'($urandom));
    end else begin
      if (pick < 18 && major_limit != 8'hFF) major = 8'($urandom_range(major_limit + 1, 255));
      else major = 8'($urandom_range(0, major_limit));
      if (pick >= 18 && pick < 28 && count_limit != 8'hFF)
        count = $urandom_range(count_limit + 1, 255);
      else if (pick < 33) count = $urandom_range(0, count_limit);
      else count = $urandom_range(0, (count_limit < 5) ? count_limit : 5);
      word = $urandom;
      fb.push_back(major);
      fb.push_back(word[7:0]);
      fb.push_back(8'(count));
      fb.push_back(word[15:8]);
      word = maybe_absent(32'h0);
      for (int k = 0; k < 4; k++) fb.push_back(word[8*k +: 8]);
      for (int i = 0; i < count && i < 6; i++) begin
        word = $urandom;
        fb.push_back(word[7:0]);
        fb.push_back(word[15:8]);
        word = maybe_absent(32'(PCT_ABSENT));
        fb.push_back(word[7:0]);
        word = maybe_absent(32'(PCT_ABSENT));
        fb.push_back(word[7:0]);
        repeat (2) begin
          word = maybe_absent(32'h0);
          for (int k = 0; k < 4; k++) fb.push_back(word[8*k +: 8]);
        end
        word = maybe_absent(32'(CREDITS_ABSENT));
        fb.push_back(word[7:0]);
        fb.push_back(word[15:8]);
        word = $urandom;
        fb.push_back(word[7:0]);
        fb.push_back(word[15:8]);
      end
      // trailing bytes past the counted records
      if ($urandom_range(99) < 20) repeat ($urandom_range(1, 5)) fb.push_back(8'($urandom));
      if (count > 6 || $urandom_range(99) < 15) begin
        cut = $urandom_range(1, fb.size());
        while (fb.size() > cut) void'(fb.pop_back());
      end
    end
    frames++;
    foreach (fb[i]) send_byte({fb[i], i == fb.size() - 1});
  endtask

  // receiver stalls at random except in the steady stretch
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 19);
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // compare each result transfer with the oldest owed result
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $error("result of kind %0d with none owed", out_data.result_kind);
        errors++;
      end else begin
        want = owed_results.pop_front();
        check_field("result_kind", want.result_kind, out_data.result_kind);
        check_field("index_count_or_code", want.index_count_or_code,
                    out_data.index_count_or_code);
        check_field("id_or_major", want.id_or_major, out_data.id_or_major);
        check_field("status_or_minor", want.status_or_minor, out_data.status_or_minor);
        check_field("plan_or_flags", want.plan_or_flags, out_data.plan_or_flags);
        check_field("session_pct", want.session_pct, out_data.session_pct);
        check_field("week_pct", want.week_pct, out_data.week_pct);
        check_field("reset_or_captured", want.reset_or_captured, out_data.reset_or_captured);
        check_field("week_reset_time", want.week_reset_time, out_data.week_reset_time);
        check_field("credits_times_ten", want.credits_times_ten, out_data.credits_times_ten);
        check_field("present_mask", want.present_mask, out_data.present_mask);
        check_field("last_of_run", want.last_of_run, out_data.last_of_run);
        if (want.result_kind <= KIND_STATUS) kind_seen[want.result_kind]++;
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL snapshot_frame_parser_top");
    $finish;
  end

  initial begin
    logic [7:0] setting_major [5];
    logic [7:0] setting_count [5];
    int         quota [5];
    int         stop_at;
    setting_major = '{SUPPORTED_MAJOR_RESET, 8'h00, 8'hFF, 8'h03, 8'($urandom)};
    setting_count = '{MAX_PROVIDER_COUNT_RESET, 8'h00, 8'hFF, 8'h02, 8'($urandom_range(1, 8))};
    quota = '{250, 250, 300, 300, 350};

    // short frame right after reset
    add_row(8'h5A, 1'b1, 1'b1, ST_SHORT);
    // major too new, error on the final byte
    add_row(8'hFF, 1'b0); add_row(8'h00, 1'b0); add_row(8'h03, 1'b0); add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0); add_row(8'h00, 1'b0); add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, ST_NEWMAJOR);
    // count too large, then a dropped byte ends the frame silently
    add_row(8'h01, 1'b0); add_row(8'h7F, 1'b0); add_row(8'hFF, 1'b0); add_row(8'h80, 1'b0);
    add_row(8'h11, 1'b0); add_row(8'h22, 1'b0); add_row(8'h33, 1'b0);
    add_row(8'h44, 1'b0, 1'b1, ST_BADCOUNT);
    add_row(8'hC3, 1'b1);
    // empty frame completing on the final byte
    add_row(8'h00, 1'b0); add_row(8'hFF, 1'b0); add_row(8'h00, 1'b0); add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0); add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b1, 1'b1, ST_OK);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    frames += 4;

    // random frames under several register settings
    for (int s = 0; s < 5; s++) begin
      if (s > 0) begin
        drain();
        write_limits(setting_major[s], setting_count[s]);
      end
      steady = (s == 2);
      stop_at = sent_bytes + quota[s];
      while (sent_bytes < stop_at) play_random_frame();
    end
    steady = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d frames, %0d bytes, under five register settings", frames, sent_bytes);
    $display("checked %0d headers, %0d records, %0d status results",
             kind_seen[KIND_HEADER], kind_seen[KIND_RECORD], kind_seen[KIND_STATUS]);
    if (errors == 0) begin
      $display("PASS snapshot_frame_parser_top");
    end else begin
      $display("FAIL snapshot_frame_parser_top");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sfp_pkg.sv
rtl/sfp_parser.sv
rtl/sfp_result_fifo.sv
rtl/snapshot_frame_parser_top.sv
tb/sv/snapshot_frame_parser_top_test.sv
